>>> hw/rtl/nstg_pkg.sv
// Package for the note sequencer tone generator: phase type, register
// indexes, reset values and the timer reload table.
// Has no dependencies; used by note_sequencer_tone_generator.
package nstg_pkg;

  typedef enum logic [1:0] {
    PH_FETCH  = 2'd0,
    PH_TONE   = 2'd1,
    PH_SILENT = 2'd2
  } ph_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_GAP_MS = 3'd4;

  localparam logic [15:0] TICKS_PER_MS_RST = 16'd1000;
  localparam logic [9:0]  BEAT_MS_RST      = 10'd180;
  localparam logic [15:0] REST_MS_RST      = 16'd100;
  localparam logic [15:0] END_GAP_MS_RST   = 16'd1000;

  localparam logic [7:0] CODE_END  = 8'h00;
  localparam logic [7:0] CODE_REST = 8'hff;

  localparam int SONG_POS_W = 7;
  localparam int MS_W       = 18;

  // Reload values indexed by octave-1 and degree-1.
  localparam logic [15:0] RELOAD_TABLE [0:2][0:6] = '{
    '{16'hf88c, 16'hf95b, 16'hfa15, 16'hfa67, 16'hfb04, 16'hfb90, 16'hfc0c},
    '{16'hfc44, 16'hfcac, 16'hfd09, 16'hfd34, 16'hfd82, 16'hfdc8, 16'hfe06},
    '{16'hfe22, 16'hfe56, 16'hfe6e, 16'hfe9a, 16'hfec1, 16'hfee4, 16'hff03}
  };

endpackage

>>> hw/rtl/note_sequencer_tone_generator.sv
// Top level of the note sequencer tone generator: song memory, phase
// control, tone and millisecond timers, and the result register.
// Depends on nstg_pkg.
//
// Usage: each input transaction on the s_axis channel is either one timer
// tick (s_axis_tuser = 0) or one song memory write (s_axis_tuser = 1, with
// the address and byte in s_axis_tdata). Every input transaction produces
// exactly one output transaction on m_axis carrying the buzzer level, the
// tone flag and the current song position after that input took effect.
// The result is registered: it appears on m_axis the cycle after the
// input is accepted. Throughput is one input per cycle while the receiver
// does not stall; the song memory is read ahead at the next position (with
// write forwarding), so even a fetch tick needs no wait for a memory read.
// If the receiver stalls, the result register holds its transaction and
// s_axis_tready drops until it is taken; s_axis_tready is high whenever the
// result register is empty or being drained in the same cycle.
// Configuration writes on the cfg channel are always accepted and take
// effect on the next cycle; they should only be issued while idle.
// Reset clears the player to song start in the fetch phase, loads the
// register reset values and empties the result register. The song memory
// is not cleared; only bytes that were written may be played.
module note_sequencer_tone_generator #(
  parameter int SONG_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [6:0] song_addr, [14:7] song_byte, [15] zero
  input  logic        s_axis_tuser,  // [0] cmd
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] beep, [1] tone_on, [8:2] song_pos, [15:9] zero
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [nstg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
  localparam int ADDR_SPAN = 1 << nstg_pkg::SONG_POS_W;

  // Configuration registers.
  logic        enable;
  logic [15:0] ticks_per_ms;
  logic [9:0]  beat_ms;
  logic [15:0] rest_ms;
  logic [15:0] end_gap_ms;

  // Player state.
  nstg_pkg::ph_t phase, phase_next;
  logic [PW-1:0]               position, position_next;
  logic [15:0]                 reload_value, reload_value_next;
  logic [15:0]                 tone_counter, tone_counter_next;
  logic                        beep_level, beep_level_next;
  logic [15:0]                 ms_prescaler, ms_prescaler_next;
  logic [nstg_pkg::MS_W-1:0]   ms_remaining, ms_remaining_next;

  // Song memory and its look-ahead read registers.
  logic [7:0]    song_mem [SONG_DEPTH];
  logic [7:0]    code_q;
  logic [7:0]    beats_q;
  logic [PW-1:0] code_addr;
  logic [PW-1:0] beats_addr;

  logic          accept;
  logic          is_write;
  logic          is_tick;
  logic [6:0]    song_addr;
  logic [7:0]    song_byte;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] addr_mod_tbl [ADDR_SPAN];

  // Fetch decode.
  logic [3:0]               oct;
  logic [3:0]               deg;
  logic                     note_ok;
  logic [1:0]               oct_idx;
  logic [2:0]               deg_idx;
  logic [nstg_pkg::MS_W-1:0] beat_len;
  logic [PW:0]              pos_plus2;
  logic [PW-1:0]            pos_adv;
  logic [16:0]              presc_inc;
  logic                     ms_done;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign song_addr     = s_axis_tdata[6:0];
  assign song_byte     = s_axis_tdata[14:7];
  assign is_write      = accept && s_axis_tuser;
  assign is_tick       = accept && !s_axis_tuser;

  // Write address reduced modulo the memory depth, worked out at elaboration.
  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_addr_mod
    assign addr_mod_tbl[g] = PW'(g % SONG_DEPTH);
  end
  assign wr_addr = addr_mod_tbl[song_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      ticks_per_ms <= nstg_pkg::TICKS_PER_MS_RST;
      beat_ms      <= nstg_pkg::BEAT_MS_RST;
      rest_ms      <= nstg_pkg::REST_MS_RST;
      end_gap_ms   <= nstg_pkg::END_GAP_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nstg_pkg::REG_ENABLE:       enable       <= cfg_data[0];
        nstg_pkg::REG_TICKS_PER_MS: ticks_per_ms <= cfg_data;
        nstg_pkg::REG_BEAT_MS:      beat_ms      <= cfg_data[9:0];
        nstg_pkg::REG_REST_MS:      rest_ms      <= cfg_data;
        nstg_pkg::REG_END_GAP_MS:   end_gap_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fetch decode of the bytes waiting at the current position.
  assign oct      = code_q[7:4];
  assign deg      = code_q[3:0];
  assign note_ok  = (oct >= 4'd1) && (oct <= 4'd3) && (deg >= 4'd1) && (deg <= 4'd7);
  assign oct_idx  = 2'(oct - 4'd1);
  assign deg_idx  = 3'(deg - 4'd1);
  assign beat_len = nstg_pkg::MS_W'(beats_q) * nstg_pkg::MS_W'(beat_ms);

  assign pos_plus2 = {1'b0, position} + (PW+1)'(2);
  assign pos_adv   = (pos_plus2 >= (PW+1)'(SONG_DEPTH))
                   ? PW'(pos_plus2 - (PW+1)'(SONG_DEPTH)) : PW'(pos_plus2);

  // A zero ticks_per_ms makes every tick a millisecond, the same as one.
  assign presc_inc = {1'b0, ms_prescaler} + 17'd1;
  assign ms_done   = presc_inc >= {1'b0, ticks_per_ms};

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (is_tick) begin
      if (!enable) begin
        phase_next = nstg_pkg::PH_FETCH;
      end else if (phase == nstg_pkg::PH_FETCH) begin
        if (code_q != nstg_pkg::CODE_END && code_q != nstg_pkg::CODE_REST && note_ok) begin
          phase_next = nstg_pkg::PH_TONE;
        end else begin
          phase_next = nstg_pkg::PH_SILENT;
        end
      end else if (ms_remaining == '0) begin
        phase_next = nstg_pkg::PH_FETCH;
      end
    end
  end

  // Next values of the position, timers and buzzer level.
  always_comb begin
    position_next     = position;
    reload_value_next = reload_value;
    tone_counter_next = tone_counter;
    beep_level_next   = beep_level;
    ms_prescaler_next = ms_prescaler;
    ms_remaining_next = ms_remaining;
    if (is_tick) begin
      if (!enable) begin
        position_next     = '0;
        tone_counter_next = '0;
        beep_level_next   = 1'b0;
        ms_prescaler_next = '0;
        ms_remaining_next = '0;
      end else if (phase == nstg_pkg::PH_FETCH) begin
        ms_prescaler_next = '0;
        if (code_q == nstg_pkg::CODE_END) begin
          position_next     = '0;
          ms_remaining_next = nstg_pkg::MS_W'(end_gap_ms);
        end else if (code_q == nstg_pkg::CODE_REST) begin
          position_next     = pos_adv;
          ms_remaining_next = nstg_pkg::MS_W'(rest_ms);
        end else begin
          position_next     = pos_adv;
          ms_remaining_next = beat_len;
          if (note_ok) begin
            reload_value_next = nstg_pkg::RELOAD_TABLE[oct_idx][deg_idx];
            tone_counter_next = nstg_pkg::RELOAD_TABLE[oct_idx][deg_idx];
          end
        end
      end else if (ms_remaining != '0) begin
        if (phase == nstg_pkg::PH_TONE) begin
          if (tone_counter == 16'hffff) begin
            tone_counter_next = reload_value;
            beep_level_next   = !beep_level;
          end else begin
            tone_counter_next = tone_counter + 16'd1;
          end
        end
        if (ms_done) begin
          ms_prescaler_next = '0;
          ms_remaining_next = ms_remaining - nstg_pkg::MS_W'(1);
        end else begin
          ms_prescaler_next = presc_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= nstg_pkg::PH_FETCH;
      position     <= '0;
      reload_value <= '0;
      tone_counter <= '0;
      beep_level   <= 1'b0;
      ms_prescaler <= '0;
      ms_remaining <= '0;
    end else begin
      phase        <= phase_next;
      position     <= position_next;
      reload_value <= reload_value_next;
      tone_counter <= tone_counter_next;
      beep_level   <= beep_level_next;
      ms_prescaler <= ms_prescaler_next;
      ms_remaining <= ms_remaining_next;
    end
  end

  // The memory is read ahead at the position the player will hold next
  // cycle, so the pair is ready the moment a fetch tick arrives. A write
  // to one of those addresses in the same cycle is forwarded.
  assign code_addr  = position_next;
  assign beats_addr = (position_next == PW'(SONG_DEPTH - 1)) ? '0 : position_next + PW'(1);

  always_ff @(posedge clk) begin
    if (is_write) begin
      song_mem[wr_addr] <= song_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (is_write && wr_addr == code_addr) begin
      code_q <= song_byte;
    end else begin
      code_q <= song_mem[code_addr];
    end
    if (is_write && wr_addr == beats_addr) begin
      beats_q <= song_byte;
    end else begin
      beats_q <= song_mem[beats_addr];
    end
  end

  // Result register: loaded with the state after each accepted input.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {7'd0,
                       nstg_pkg::SONG_POS_W'(position_next),
                       (phase_next == nstg_pkg::PH_TONE),
                       beep_level_next};
    end
  end

endmodule

>>> sim/nstg_melody_check_pkg.sv
// Scoreboard for the note sequencer tone generator test: a tick-level model
// of the melody player and the queue of player outputs still awaited.
// Depends on nstg_pkg for the phase type, register indexes and note codes.
package nstg_melody_check_pkg;
  import nstg_pkg::*;

  // Timer reload per note, ordered by octave 1..3, then degree 1..7.
  localparam logic [15:0] PITCH_RELOAD [0:20] = '{
    16'hf88c, 16'hf95b, 16'hfa15, 16'hfa67, 16'hfb04, 16'hfb90, 16'hfc0c,
    16'hfc44, 16'hfcac, 16'hfd09, 16'hfd34, 16'hfd82, 16'hfdc8, 16'hfe06,
    16'hfe22, 16'hfe56, 16'hfe6e, 16'hfe9a, 16'hfec1, 16'hfee4, 16'hff03
  };

  typedef struct packed {
    logic       beep;
    logic       tone_on;
    logic [6:0] song_pos;
  } player_view_t;

  class buzzer_scoreboard;
    logic [7:0]   song_mem [128];
    logic [6:0]   position;
    logic [15:0]  reload;
    logic [15:0]  tone_count;
    logic         beep;
    logic [15:0]  prescale;
    logic [17:0]  ms_left;
    ph_t          phase;
    logic         enable;
    logic [15:0]  ticks_per_ms;
    logic [9:0]   beat_ms;
    logic [15:0]  rest_ms;
    logic [15:0]  end_gap_ms;
    player_view_t awaited_views [$];
    int           errors;
    int           checked;
    int           tone_results;

    function new();
      foreach (song_mem[i]) song_mem[i] = '0;
      position     = '0;
      reload       = '0;
      tone_count   = '0;
      beep         = 1'b0;
      prescale     = '0;
      ms_left      = '0;
      phase        = PH_FETCH;
      enable       = 1'b0;
      ticks_per_ms = TICKS_PER_MS_RST;
      beat_ms      = BEAT_MS_RST;
      rest_ms      = REST_MS_RST;
      end_gap_ms   = END_GAP_MS_RST;
      errors       = 0;
      checked      = 0;
      tone_results = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        REG_ENABLE:       enable       = value[0];
        REG_TICKS_PER_MS: ticks_per_ms = value;
        REG_BEAT_MS:      beat_ms      = value[9:0];
        REG_REST_MS:      rest_ms      = value;
        REG_END_GAP_MS:   end_gap_ms   = value;
        default: ;
      endcase
    endfunction

    // One timer tick of the player.
    function void advance_tick();
      logic [7:0]  code;
      logic [7:0]  beats;
      logic [6:0]  beat_addr;
      logic [16:0] next_scale;
      int          note_idx;
      if (!enable) begin
        position   = '0;
        tone_count = '0;
        beep       = 1'b0;
        prescale   = '0;
        ms_left    = '0;
        phase      = PH_FETCH;
        return;
      end
      if (phase == PH_FETCH) begin
        beat_addr = position + 7'd1;
        code      = song_mem[position];
        beats     = song_mem[beat_addr];
        prescale  = '0;
        if (code == CODE_END) begin
          position = '0;
          phase    = PH_SILENT;
          ms_left  = 18'(end_gap_ms);
        end else begin
          position = position + 7'd2;
          if (code == CODE_REST) begin
            phase   = PH_SILENT;
            ms_left = 18'(rest_ms);
          end else begin
            ms_left = 18'(beats) * 18'(beat_ms);
            if (code[7:4] >= 4'd1 && code[7:4] <= 4'd3 &&
                code[3:0] >= 4'd1 && code[3:0] <= 4'd7) begin
              note_idx   = (int'(code[7:4]) - 1) * 7 + int'(code[3:0]) - 1;
              reload     = PITCH_RELOAD[note_idx];
              tone_count = reload;
              phase      = PH_TONE;
            end else begin
              phase = PH_SILENT;
            end
          end
        end
        return;
      end
      if (ms_left == '0) begin
        phase = PH_FETCH;
        return;
      end
      if (phase == PH_TONE) begin
        if (tone_count == 16'hffff) begin
          tone_count = reload;
          beep       = ~beep;
        end else begin
          tone_count = tone_count + 16'd1;
        end
      end
      next_scale = {1'b0, prescale} + 17'd1;
      if (next_scale >= {1'b0, ticks_per_ms}) begin
        prescale = '0;
        ms_left  = ms_left - 18'd1;
      end else begin
        prescale = next_scale[15:0];
      end
    endfunction

    function void note_input(logic cmd, logic [6:0] addr, logic [7:0] data);
      player_view_t view;
      if (cmd) song_mem[addr] = data;
      else advance_tick();
      view.beep     = beep;
      view.tone_on  = (phase == PH_TONE);
      view.song_pos = position;
      awaited_views.push_back(view);
    endfunction

    function void report_field(string field, longint unsigned stamp, int want, int got);
      if (want != got) begin
        errors++;
        $display("[%0d ns] %s mismatch: expected %0d, actual %0d", stamp, field, want, got);
      end
    endfunction

    function void check_result(logic [15:0] tdata, longint unsigned stamp);
      player_view_t want;
      if (awaited_views.size() == 0) begin
        errors++;
        $display("[%0d ns] unexpected result: expected none, actual tdata 0x%04h",
                 stamp, tdata);
        return;
      end
      want = awaited_views.pop_front();
      checked++;
      if (want.tone_on) tone_results++;
      report_field("beep", stamp, want.beep, tdata[0]);
      report_field("tone_on", stamp, want.tone_on, tdata[1]);
      report_field("song_pos", stamp, want.song_pos, tdata[8:2]);
    endfunction
  endclass

endpackage

>>> sim/note_sequencer_tone_generator_test.sv
// Self-checking test of note_sequencer_tone_generator: loads songs, plays
// them under several register settings and checks every output transaction.
// Depends on nstg_pkg and nstg_melody_check_pkg.
module note_sequencer_tone_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nstg_pkg::*;
  import nstg_melody_check_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // The opening song walks through the notable note codes: the lowest and
  // the highest pitch (the latter long enough for the buzzer to toggle), a
  // rest whose beat byte must be ignored, a bad octave, a bad degree, a
  // zero degree, a note with zero beats, and finally the end code.
  localparam logic [7:0] OPENING_SONG [0:15] = '{
    8'h11, 8'd3, 8'h37, 8'd255, CODE_REST, 8'd9, 8'h41, 8'd1,
    8'h18, 8'd1, 8'h10, 8'd1, 8'h21, 8'd0, CODE_END, 8'd5
  };

  buzzer_scoreboard tracker = new();

  // Flags shared between the stimulus and the result sink.
  bit steady_src;
  bit steady_sink;
  int sink_hold_req;
  int input_count;
  int write_count;
  int setting_count;

  note_sequencer_tone_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // One input transaction, after a random idle gap. Inputs change on the
  // falling edge; acceptance is judged at the rising edge.
  task automatic send_item(input logic cmd, input logic [6:0] addr, input logic [7:0] data);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, data, addr};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_input(cmd, addr, data);
    input_count++;
    if (cmd) write_count++;
  endtask

  // Stop offering input and wait until every expected result has arrived.
  // The block answers each input in the cycle after it is accepted, so an
  // extra wait once every result is in leaves it quiet.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only while the block is idle. Enable goes last so the
  // player never runs with a half-written setting.
  task automatic apply_settings(input logic en, input logic [15:0] tpm, input logic [9:0] beat,
                                input logic [15:0] rest, input logic [15:0] gap,
                                input bit steady);
    drain();
    write_reg(REG_TICKS_PER_MS, tpm);
    write_reg(REG_BEAT_MS, {6'd0, beat});
    write_reg(REG_REST_MS, rest);
    write_reg(REG_END_GAP_MS, gap);
    write_reg(REG_ENABLE, {15'd0, en});
    steady_src  = steady;
    steady_sink = steady;
    setting_count++;
  endtask

  // Writes all of song memory, so no fetch ever reads an unwritten byte.
  // Codes are mostly real notes, with rests, end codes (when allowed) and
  // arbitrary bytes that may be invalid codes.
  task automatic load_song(input bit opening, input bit allow_end);
    logic [7:0] song [128];
    int         roll;
    for (int p = 0; p < 64; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) song[2*p] = {4'($urandom_range(1, 3)), 4'($urandom_range(1, 7))};
      else if (roll < 72) song[2*p] = CODE_REST;
      else if (roll < 76) song[2*p] = allow_end ? CODE_END : CODE_REST;
      else song[2*p] = 8'($urandom_range(0, 255));
      if (!allow_end && song[2*p] == CODE_END) song[2*p] = CODE_REST;
      roll = $urandom_range(0, 99);
      if (roll < 70) song[2*p+1] = 8'($urandom_range(0, 3));
      else if (roll < 92) song[2*p+1] = 8'($urandom_range(4, 12));
      else song[2*p+1] = 8'($urandom_range(13, 40));
    end
    if (opening) begin
      for (int a = 0; a < 16; a++) song[a] = OPENING_SONG[a];
    end
    for (int a = 0; a < 128; a++) send_item(1'b1, 7'(a), song[a]);
  endtask

  // Mostly timer ticks with random, ignored data; some song writes anywhere
  // in memory. Optionally the receiver is held off at one point, and the
  // sender pauses at another until all results are in.
  task automatic run_ticks(input int count, input int write_pct, input int hold_at,
                           input int pause_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) sink_hold_req = 90;
      if (k == pause_at) drain();
      if ($urandom_range(0, 99) < write_pct)
        send_item(1'b1, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
      else
        send_item(1'b0, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Result sink: ready changes on the falling edge, with random stalls and
  // an occasional long hold-off requested by the stimulus. Every accepted
  // output transaction goes to the scoreboard.
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        stall_left    = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady_sink && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tdata, $time);
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ENABLE;
    cfg_data      = '0;
    steady_src    = 1'b0;
    steady_sink   = 1'b0;
    sink_hold_req = 0;
    input_count   = 0;
    write_count   = 0;
    setting_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The player is disabled after reset, so the opening song loads while
    // it sits at song start. It then plays with one tick per millisecond,
    // one millisecond per beat, zero-length rests and a short end gap, and
    // comes round again after the end code.
    load_song(1'b1, 1'b1);
    apply_settings(1'b1, 16'd1, 10'd1, 16'd0, 16'd2, 1'b0);
    run_ticks(300, 0, 100, -1);

    // Random song with end codes, a slower millisecond and a pause in the
    // middle that lets the results catch up.
    apply_settings(1'b1, 16'd2, 10'd3, 16'd5, 16'd4, 1'b0);
    load_song(1'b0, 1'b1);
    run_ticks(100, 8, -1, 50);

    // Zero ticks per millisecond behaves as one. The song loaded here has
    // no end codes.
    apply_settings(1'b1, 16'd0, 10'd1, 16'd0, 16'd0, 1'b0);
    load_song(1'b0, 1'b0);
    run_ticks(100, 3, 60, -1);

    // Every length register at its maximum, with no idling on either side.
    apply_settings(1'b1, 16'hffff, 10'd1023, 16'hffff, 16'hffff, 1'b1);
    run_ticks(60, 5, -1, -1);

    // Disabled: each tick sends the player back to song start.
    apply_settings(1'b0, 16'd3, 10'd7, 16'd1, 16'd1, 1'b0);
    run_ticks(40, 20, -1, -1);

    // Zero milliseconds per beat and zero-length rests make every pair end
    // right after its fetch, so the position runs past the top of memory
    // and wraps.
    apply_settings(1'b1, 16'd1, 10'd0, 16'd0, 16'd0, 1'b1);
    run_ticks(160, 5, -1, -1);

    apply_settings(1'b1, 16'd1, 10'd2, 16'd1, 16'd1, 1'b0);
    run_ticks(100, 5, 30, 70);

    drain();
    $display("Played %0d input transactions (%0d song writes) under %0d register settings;",
             input_count, write_count, setting_count);
    $display("checked %0d results, %0d of them with a tone sounding.",
             tracker.checked, tracker.tone_results);
    if (tracker.errors == 0 && tracker.awaited_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Timeout with %0d results still awaited.", tracker.awaited_views.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
